// ===== rtl/lpgt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpgt_pkg: shared types and constants for the linear probe group table
// Sizes, status codes, request/result structs and controller states.
// ----------------------------------------------------------------------------
package lpgt_pkg;

  localparam int LOG_CAPACITY = 10;
  localparam int KEY_WIDTH    = 64;
  localparam int NUM_BUCKETS  = 1 << LOG_CAPACITY;
  localparam int ROW_BITS     = 10;
  localparam int ROW_DEPTH    = 1 << ROW_BITS;
  localparam int LAP_BITS     = LOG_CAPACITY + 1;

  localparam logic [9:0] LIMIT_RESET = 10'd768;

  localparam logic [1:0] ST_MATCHED   = 2'd0;
  localparam logic [1:0] ST_INSERTED  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic REG_ENTRY_LIMIT = 1'b0;

  typedef struct packed {
    logic [63:0] hash_value;
    logic [63:0] group_key;
    logic        create_allowed;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] row_index;
    logic [9:0] group_count;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BUCKET,
    S_KEY,
    S_CHECK,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;      // zero one valid mark per cycle after reset
    logic load;       // capture request, set first bucket
    logic rd_bucket;  // read bucket memories at probe index
    logic rd_key;     // read key store at bucket row
    logic advance;    // step to next bucket
    logic insert;     // write new group
    logic finish;     // drive result
    logic [1:0] status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done; // last valid mark being cleared
    logic empty;      // current bucket not valid
    logic hash_eq;
    logic key_eq;
    logic lap_done;   // whole table probed
    logic at_limit;
    logic create;
  } dp_stat_t;

endpackage

// ===== rtl/linear_probe_group_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_group_table: find-or-insert engine over a linear-probe table
// Top level: APB register, probe controller and table datapath.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. After reset busy
// stays high while a clearing pass zeroes the bucket valid marks, one per
// cycle. The hash masked to the table size picks the first bucket; each
// probed bucket is stepped through a bucket memory read, a key store read
// at the bucket's row and a compare, and the result is then registered.
// busy drops in the cycle after the result, so a new request is taken only
// after the previous one has shown its result. A probe run ends after at
// most 1025 probes, when a full lap of 1024 buckets finds neither a match
// nor an empty bucket. The result shows for one cycle with result_valid
// high; the receiver cannot stall it.
// The entry_limit register (offset 0, reset 768) caps how many groups are
// stored. The group count clears at reset.
// ----------------------------------------------------------------------------
module linear_probe_group_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lpgt_pkg::request_t request,
  output logic               result_valid,
  output lpgt_pkg::result_t  result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [9:0]          entry_limit;
  lpgt_pkg::dp_cmd_t   cmd;
  lpgt_pkg::dp_stat_t  stat;

  // paddr is one bit: byte offset 4 -> index 1, ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= lpgt_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == lpgt_pkg::REG_ENTRY_LIMIT) begin
      entry_limit <= pwdata[9:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == lpgt_pkg::REG_ENTRY_LIMIT) ? {22'd0, entry_limit} : 32'd0;

  lpgt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lpgt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (request),
    .entry_limit (entry_limit),
    .cmd         (cmd),
    .stat        (stat),
    .done        (result_valid),
    .result      (result)
  );

endmodule

// ===== rtl/lpgt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpgt_ctrl: probe sequencer
// Clears the valid marks after reset, then steps each request through
// bucket read, key read and decision.
// ----------------------------------------------------------------------------
module lpgt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lpgt_pkg::dp_stat_t stat,
  output lpgt_pkg::dp_cmd_t  cmd
);

  lpgt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpgt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lpgt_pkg::S_CLEAR:  if (stat.clear_done) state_next = lpgt_pkg::S_IDLE;
      lpgt_pkg::S_IDLE:   if (start) state_next = lpgt_pkg::S_BUCKET;
      lpgt_pkg::S_BUCKET: state_next = lpgt_pkg::S_KEY;
      lpgt_pkg::S_KEY:    state_next = lpgt_pkg::S_CHECK;
      lpgt_pkg::S_CHECK: begin
        if (stat.lap_done || stat.empty || (stat.hash_eq && stat.key_eq))
          state_next = lpgt_pkg::S_DONE;
        else
          state_next = lpgt_pkg::S_BUCKET;
      end
      lpgt_pkg::S_DONE:   state_next = lpgt_pkg::S_IDLE;
      default:            state_next = lpgt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      lpgt_pkg::S_CLEAR:  cmd.clear = 1'b1;
      lpgt_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      lpgt_pkg::S_BUCKET: cmd.rd_bucket = 1'b1;
      lpgt_pkg::S_KEY:    cmd.rd_key = 1'b1;
      lpgt_pkg::S_CHECK: begin
        if (stat.lap_done) begin
          cmd.finish = 1'b1;
          cmd.status = stat.create ? lpgt_pkg::ST_FULL : lpgt_pkg::ST_NOT_FOUND;
        end else if (stat.empty) begin
          cmd.finish = 1'b1;
          if (!stat.create) begin
            cmd.status = lpgt_pkg::ST_NOT_FOUND;
          end else if (stat.at_limit) begin
            cmd.status = lpgt_pkg::ST_FULL;
          end else begin
            cmd.status = lpgt_pkg::ST_INSERTED;
            cmd.insert = 1'b1;
          end
        end else if (stat.hash_eq && stat.key_eq) begin
          cmd.finish = 1'b1;
          cmd.status = lpgt_pkg::ST_MATCHED;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      lpgt_pkg::S_DONE:   busy = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

endmodule

// ===== rtl/lpgt_datapath.sv =====
// ----------------------------------------------------------------------------
// lpgt_datapath: bucket and key memories, probe index, group counter
// Valid, hash, row and key stores in synchronous RAM; valid marks are
// zeroed by a clearing pass after reset.
// ----------------------------------------------------------------------------
module lpgt_datapath (
  input  logic               clk,
  input  logic               rst,
  input  lpgt_pkg::request_t req,
  input  logic [9:0]         entry_limit,
  input  lpgt_pkg::dp_cmd_t  cmd,
  output lpgt_pkg::dp_stat_t stat,
  output logic               done,
  output lpgt_pkg::result_t  result
);

  logic                             bucket_valid [lpgt_pkg::NUM_BUCKETS];
  logic [63:0]                      bucket_hash [lpgt_pkg::NUM_BUCKETS];
  logic [lpgt_pkg::ROW_BITS-1:0]    bucket_row  [lpgt_pkg::NUM_BUCKETS];
  logic [lpgt_pkg::KEY_WIDTH-1:0]   key_store   [lpgt_pkg::ROW_DEPTH];

  logic [63:0]                      hash;
  logic [lpgt_pkg::KEY_WIDTH-1:0]   key;
  logic                             create;
  logic [lpgt_pkg::LOG_CAPACITY-1:0] probe;
  logic [lpgt_pkg::LOG_CAPACITY-1:0] clear_idx;
  logic [lpgt_pkg::LAP_BITS-1:0]    probes;
  logic [9:0]                       stored_groups;
  logic                             rd_valid;
  logic [63:0]                      rd_hash;
  logic [lpgt_pkg::ROW_BITS-1:0]    rd_row;
  logic [lpgt_pkg::KEY_WIDTH-1:0]   rd_key;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hash   <= req.hash_value;
      key    <= req.group_key[lpgt_pkg::KEY_WIDTH-1:0];
      create <= req.create_allowed;
      probe  <= req.hash_value[lpgt_pkg::LOG_CAPACITY-1:0];
    end else if (cmd.advance) begin
      probe  <= probe + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probes <= '0;
    end else if (cmd.load) begin
      probes <= '0;
    end else if (cmd.advance) begin
      probes <= probes + 1'b1;
    end
  end

  // clearing pass address, one valid mark per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
    end else if (cmd.clear) begin
      clear_idx <= clear_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_bucket) begin
      rd_valid <= bucket_valid[probe];
      rd_hash  <= bucket_hash[probe];
      rd_row   <= bucket_row[probe];
    end
    if (cmd.rd_key) begin
      rd_key <= key_store[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      bucket_valid[clear_idx] <= 1'b0;
    end else if (cmd.insert) begin
      bucket_valid[probe] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      bucket_hash[probe] <= hash;
      bucket_row[probe]  <= stored_groups;
      key_store[stored_groups] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_groups <= '0;
    end else if (cmd.insert) begin
      stored_groups <= stored_groups + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status    <= cmd.status;
      result.row_index <= (cmd.status == lpgt_pkg::ST_INSERTED) ? stored_groups :
                          (cmd.status == lpgt_pkg::ST_MATCHED)  ? rd_row : '0;
      result.group_count <= cmd.insert ? stored_groups + 1'b1 : stored_groups;
    end
  end

  always_comb begin
    stat.clear_done = (clear_idx == '1);
    stat.empty      = !rd_valid;
    stat.hash_eq    = (rd_hash == hash);
    stat.key_eq     = (rd_key == key);
    stat.lap_done   = (probes == lpgt_pkg::LAP_BITS'(lpgt_pkg::NUM_BUCKETS));
    stat.at_limit   = (stored_groups >= entry_limit);
    stat.create     = create;
  end

endmodule

// ===== test/tb_linear_probe_group_table.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_group_table: self-checking bench for the group table
// Queued find-or-insert requests drive the command port while a monitor
// checks every result against a shadow probe table kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_probe_group_table;

  localparam int LIMIT_CYCLES = 30000000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  lpgt_pkg::request_t   request;
  logic                 result_valid;
  lpgt_pkg::result_t    result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic                 paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  linear_probe_group_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow table: mirrors bucket memories, key store and counters.
  bit          shadow_valid [lpgt_pkg::NUM_BUCKETS];
  logic [63:0] shadow_hash  [lpgt_pkg::NUM_BUCKETS];
  logic [9:0]  shadow_row   [lpgt_pkg::NUM_BUCKETS];
  logic [63:0] shadow_key   [lpgt_pkg::ROW_DEPTH];
  logic [9:0]  shadow_groups;
  logic [9:0]  shadow_limit;

  lpgt_pkg::request_t pending_q[$];    // requests waiting for the driver
  lpgt_pkg::result_t  outcome_q[$];    // predicted results, oldest first
  logic [63:0] known_hash[$];   // hash/key pairs queued with create allowed, for matches
  logic [63:0] known_key[$];

  int errors = 0;
  int sent = 0;
  int checked = 0;
  int n_status [4];
  int idle_pct = 0;
  longint cycles = 0;

  // Walk the shadow table exactly as the engine does and update it.
  function automatic lpgt_pkg::result_t probe_group(lpgt_pkg::request_t rq);
    lpgt_pkg::result_t r;
    logic [9:0]  b;
    logic [63:0] k;
    k = rq.group_key;
    b = rq.hash_value[lpgt_pkg::LOG_CAPACITY-1:0];
    r.status = rq.create_allowed ? lpgt_pkg::ST_FULL : lpgt_pkg::ST_NOT_FOUND;
    r.row_index = '0;
    for (int p = 0; p < lpgt_pkg::NUM_BUCKETS; p++) begin
      if (!shadow_valid[b]) begin
        if (!rq.create_allowed) begin
          r.status = lpgt_pkg::ST_NOT_FOUND;
        end else if (shadow_groups >= shadow_limit) begin
          r.status = lpgt_pkg::ST_FULL;
        end else begin
          r.row_index = shadow_groups;
          shadow_valid[b] = 1'b1;
          shadow_hash[b] = rq.hash_value;
          shadow_row[b] = shadow_groups;
          shadow_key[shadow_groups] = k;
          shadow_groups = shadow_groups + 10'd1;
          r.status = lpgt_pkg::ST_INSERTED;
        end
        break;
      end
      if (shadow_hash[b] == rq.hash_value && shadow_key[shadow_row[b]] == k) begin
        r.row_index = shadow_row[b];
        r.status = lpgt_pkg::ST_MATCHED;
        break;
      end
      b = b + 10'd1;  // wraps at the last bucket
    end
    r.group_count = shadow_groups;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want, checked);
  endtask

  task automatic add_request(logic [63:0] h, logic [63:0] k, logic c);
    lpgt_pkg::request_t rq;
    rq.hash_value = h;
    rq.group_key = k;
    rq.create_allowed = c;
    pending_q = {pending_q, rq};
    if (c) begin
      known_hash = {known_hash, h};
      known_key = {known_key, k};
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random mix: mostly repeats of known groups and colliding hashes, so the
  // probe runs see clusters, matches and same-hash/different-key entries.
  task automatic add_random(int count, int create_pct);
    int          sel;
    int          j;
    logic [63:0] h;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45 && known_hash.size() > 0) begin
        j = $urandom_range(0, known_hash.size() - 1);
        add_request(known_hash[j], known_key[j], $urandom_range(0, 99) < create_pct);
      end else if (sel < 60 && known_hash.size() > 0) begin
        j = $urandom_range(0, known_hash.size() - 1);
        add_request(known_hash[j], rand64(), $urandom_range(0, 99) < create_pct);
      end else begin
        h = rand64();
        if ($urandom_range(0, 1)) h[9:0] = 10'($urandom_range(0, 15) * 64);
        add_request(h, rand64(), sel < 85 ? ($urandom_range(0, 99) < create_pct) : 1'b0);
      end
    end
  endtask

  // Block is idle once nothing is queued, in flight or expected.
  task automatic wait_quiet();
    while (pending_q.size() != 0 || start || busy || outcome_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == lpgt_pkg::REG_ENTRY_LIMIT) shadow_limit = data[9:0];  // other indexes ignored
  endtask

  task automatic apb_check_limit();
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= lpgt_pkg::REG_ENTRY_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {22'd0, shadow_limit}) report_mismatch("entry_limit read", prdata, shadow_limit);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 1'b0; pwdata = '0;
    for (int i = 0; i < lpgt_pkg::NUM_BUCKETS; i++) shadow_valid[i] = 1'b0;
    shadow_groups = '0;
    shadow_limit = lpgt_pkg::LIMIT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    apb_check_limit();

    // Directed: field extremes, empty lookup, insert, match, collision, wrap.
    add_request('0, '0, 1'b0);                  // empty bucket, no insert
    add_request('0, '0, 1'b1);                  // first insert, row 0
    add_request('0, '0, 1'b0);                  // match
    add_request('0, '1, 1'b1);                  // same hash other key: next bucket
    add_request('1, '1, 1'b1);                  // last bucket
    add_request('1, '0, 1'b1);                  // wraps to bucket 0, then 1, 2
    add_request('1, '0, 1'b0);                  // match after the wrap
    add_request('1, 64'h5555, 1'b0);            // probe past cluster, not found
    add_request(64'h8000_0000_0000_0000, '1, 1'b1);  // hash differs, same bucket 0
    add_request(64'h8000_0000_0000_0000, '1, 1'b1);  // match
    add_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
    add_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    add_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
    wait_quiet();

    add_random(1500, 70);
    wait_quiet();

    // Limit below the group count: every insert reports full.
    apb_write(lpgt_pkg::REG_ENTRY_LIMIT, {$urandom} & 32'hFFFF_FC00 | 32'd1);
    apb_write(~lpgt_pkg::REG_ENTRY_LIMIT, 32'd900);   // unmapped index, ignored
    apb_check_limit();
    add_random(60, 70);
    wait_quiet();

    apb_write(lpgt_pkg::REG_ENTRY_LIMIT, 32'd0);      // zero limit
    add_random(60, 80);
    wait_quiet();

    apb_write(lpgt_pkg::REG_ENTRY_LIMIT, 32'd1023);   // widest limit
    apb_check_limit();
    add_random(180, 60);
    wait_quiet();

    $display("covered %0d requests, %0d checked: matched %0d inserted %0d", sent, checked,
             n_status[lpgt_pkg::ST_MATCHED], n_status[lpgt_pkg::ST_INSERTED]);
    $display("not found %0d full %0d, %0d groups stored, limits 768/1/0/1023",
             n_status[lpgt_pkg::ST_NOT_FOUND], n_status[lpgt_pkg::ST_FULL], shadow_groups);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Driver: a request leaves when start is high and busy low; the predicted
  // result is queued at that edge. Sender idling varies by phase of the run.
  always @(posedge clk) begin
    if (!rst) begin
      case ((sent / 150) % 4)
        0: idle_pct = 0;
        1: idle_pct = 72;
        2: idle_pct = 0;   // no sender idling; results cannot be held off
        default: idle_pct = 22;
      endcase
      if (start && !busy) begin
        outcome_q = {outcome_q, probe_group(request)};
        sent++;
      end
      if (!start || !busy) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          request <= pending_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so take one on every strobe.
  always @(posedge clk) begin
    lpgt_pkg::result_t want;
    if (!rst && result_valid) begin
      if (outcome_q.size() == 0) begin
        errors++;
        $display("mismatch: result with nothing expected");
      end else begin
        want = outcome_q.pop_front();
        if (result.status !== want.status) report_mismatch("status", result.status, want.status);
        if (result.row_index !== want.row_index)
          report_mismatch("row_index", result.row_index, want.row_index);
        if (result.group_count !== want.group_count)
          report_mismatch("group_count", result.group_count, want.group_count);
        n_status[want.status]++;
      end
      checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outcome_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
